// ===== design/tpwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpwm_pkg: shared types and constants for the three-phase PWM block
// Holds beat payload structs, opcodes, match actions and widths.
// ----------------------------------------------------------------------------
package tpwm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int DEAD_WIDTH  = 12;
    localparam int PHASES      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Opcodes of an input beat; codes above OP_STOP do nothing
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_SET_ONE  = 3'd1,
        OP_SET_ALL  = 3'd2,
        OP_START    = 3'd3,
        OP_STOP     = 3'd4
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME = CFG_IDX_W'(1);

    // Generator action on a compare match
    typedef enum logic [1:0] {
        PIN_DO_NOTHING = 2'h0,
        PIN_CLEAR      = 2'h2,
        PIN_SET        = 2'h3
    } pin_act_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  phase;
        logic [15:0] duty;
    } in_beat_t;

    typedef struct packed {
        logic        high_a;
        logic        low_a;
        logic        high_b;
        logic        low_b;
        logic        high_c;
        logic        low_c;
        logic [15:0] count_now;
        logic        counting_down;
    } out_beat_t;

    // Step information sent from the counter to every phase
    typedef struct packed {
        logic tick;
        logic step_down;
    } step_ctl_t;

endpackage

// ===== design/three_phase_center_pwm_deadband.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_center_pwm_deadband: center-aligned three-phase PWM
// Shared up/down counter, per-phase compare and complementary drives
// with rising-edge dead time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------
//  in      | sink      | in_valid/in_stall | op, phase, duty
//  out     | source    | out_valid/out_stall | drives, count_now, counting_down
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One beat per cycle sustained while out_stall is low; an accepted input beat
//  passes through the input register, then the result register, from which
//  the result beat can be taken.
//  Reset clears counter, compares, generators, dead band and run flag;
//  period resets to all ones, dead time to zero.
//  An output stall holds the result register and backs up into the input
//  register; in_stall rises only while both stages are full.
// ----------------------------------------------------------------------------
module three_phase_center_pwm_deadband (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tpwm_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tpwm_pkg::out_beat_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpwm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tpwm_pkg::*;

    logic [COUNT_WIDTH-1:0] period_reg;
    logic [DEAD_WIDTH-1:0]  dead_reg;
    logic                   s1_valid_reg;
    in_beat_t               s1_data_reg;
    logic                   out_valid_reg;
    out_beat_t              out_data_reg;
    logic                   adv;
    logic                   fire;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   dir_next;
    logic                   run_next;
    step_ctl_t              step;
    logic [PHASES-1:0]      match;
    logic [PHASES-1:0]      high_next;
    logic [PHASES-1:0]      low_next;
    out_beat_t              res;

    // Result register frees when empty or taken this cycle
    assign adv       = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && adv;
    assign in_stall  = s1_valid_reg && !adv;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '1;
            dead_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PERIOD:    period_reg <= cfg_data[COUNT_WIDTH-1:0];
                CFG_DEAD_TIME: dead_reg   <= cfg_data[DEAD_WIDTH-1:0];
                default:       period_reg <= period_reg;
            endcase
        end
    end

    // Capture input beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= in_data;
        end
    end

    tpwm_counter u_counter (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .beat     (s1_data_reg),
        .period   (period_reg),
        .cnt_next (cnt_next),
        .dir_next (dir_next),
        .run_next (run_next),
        .step     (step),
        .match    (match)
    );

    for (genvar i = 0; i < PHASES; i++)
    begin : g_phase
        tpwm_phase u_phase (
            .clk       (clk),
            .rst_n     (rst_n),
            .fire      (fire),
            .step      (step),
            .match     (match[i]),
            .dead_len  (dead_reg),
            .high_next (high_next[i]),
            .low_next  (low_next[i])
        );
    end

    // Gate the drives with the run flag and assemble the result
    always_comb
    begin
        res.high_a        = run_next && high_next[0];
        res.low_a         = run_next && low_next[0];
        res.high_b        = run_next && high_next[1];
        res.low_b         = run_next && low_next[1];
        res.high_c        = run_next && high_next[2];
        res.low_c         = run_next && low_next[2];
        res.count_now     = cnt_next;
        res.counting_down = dir_next;
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= res;
        end
    end

endmodule

// ===== design/tpwm_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpwm_counter: shared up/down counter and compare stores
// Advances the counter on a tick, holds pending and active compares,
// tracks the run flag and flags compare matches for each phase.
// ----------------------------------------------------------------------------
module tpwm_counter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  tpwm_pkg::in_beat_t                  beat,
    input  logic [tpwm_pkg::COUNT_WIDTH-1:0]    period,
    output logic [tpwm_pkg::COUNT_WIDTH-1:0]    cnt_next,
    output logic                                dir_next,
    output logic                                run_next,
    output tpwm_pkg::step_ctl_t                 step,
    output logic [tpwm_pkg::PHASES-1:0]         match
);
    import tpwm_pkg::*;

    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic                   dir_reg;
    logic                   run_reg;
    logic [COUNT_WIDTH-1:0] act_reg  [PHASES];
    logic [COUNT_WIDTH-1:0] pend_reg [PHASES];
    logic [COUNT_WIDTH-1:0] act_next [PHASES];
    logic [COUNT_WIDTH-1:0] pend_next[PHASES];
    logic [COUNT_WIDTH-1:0] period_eff;
    logic                   load;

    assign period_eff = (period == '0) ? COUNT_WIDTH'(1) : period;

    // Work out the next counter, direction and compare state for this beat
    always_comb
    begin
        cnt_next       = cnt_reg;
        dir_next       = dir_reg;
        run_next       = run_reg;
        step.tick      = 1'b0;
        step.step_down = 1'b0;
        load           = 1'b0;
        for (int i = 0; i < PHASES; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        case (beat.op)
            OP_TICK:
            begin
                step.tick = 1'b1;
                if (!dir_reg && (cnt_reg < period_eff))
                begin
                    cnt_next = cnt_reg + COUNT_WIDTH'(1);
                    dir_next = (cnt_next >= period_eff);
                end
                else
                begin
                    step.step_down = 1'b1;
                    cnt_next       = cnt_reg - COUNT_WIDTH'(1);
                    dir_next       = (cnt_next != '0);
                    load           = (cnt_next == '0);
                end
            end
            OP_SET_ONE:
            begin
                for (int i = 0; i < PHASES; i++)
                begin
                    if (beat.phase == 2'(i))
                    begin
                        pend_next[i] = beat.duty;
                    end
                end
            end
            OP_SET_ALL:
            begin
                for (int i = 0; i < PHASES; i++)
                begin
                    pend_next[i] = beat.duty;
                end
            end
            OP_START:
            begin
                cnt_next = '0;
                dir_next = 1'b0;
                run_next = 1'b1;
                load     = 1'b1;
            end
            OP_STOP:
            begin
                run_next = 1'b0;
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
        for (int i = 0; i < PHASES; i++)
        begin
            act_next[i] = load ? pend_reg[i] : act_reg[i];
            match[i]    = (act_next[i] == cnt_next);
        end
    end

    // Hold counter state, advance on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            dir_reg <= 1'b0;
            run_reg <= 1'b0;
            for (int i = 0; i < PHASES; i++)
            begin
                act_reg[i]  <= '0;
                pend_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            cnt_reg <= cnt_next;
            dir_reg <= dir_next;
            run_reg <= run_next;
            for (int i = 0; i < PHASES; i++)
            begin
                act_reg[i]  <= act_next[i];
                pend_reg[i] <= pend_next[i];
            end
        end
    end

endmodule

// ===== design/tpwm_phase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpwm_phase: generator level and dead band for one phase
// Sets or clears the generator on a compare match and delays the rising
// edge of the high-side and low-side drives by the dead time.
// ----------------------------------------------------------------------------
module tpwm_phase (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  tpwm_pkg::step_ctl_t                 step,
    input  logic                                match,
    input  logic [tpwm_pkg::DEAD_WIDTH-1:0]     dead_len,
    output logic                                high_next,
    output logic                                low_next
);
    import tpwm_pkg::*;

    logic                  gen_reg;
    logic                  gen_next;
    logic                  lvl_reg  [2];
    logic                  lvl_next [2];
    logic [DEAD_WIDTH-1:0] dly_reg  [2];
    logic [DEAD_WIDTH-1:0] dly_next [2];
    logic                  target   [2];
    pin_act_t              act;

    // Pick the match action from the count direction
    always_comb
    begin
        act = PIN_DO_NOTHING;
        if (step.tick && match)
        begin
            act = step.step_down ? PIN_SET : PIN_CLEAR;
        end
        case (act)
            PIN_CLEAR: gen_next = 1'b0;
            PIN_SET:   gen_next = 1'b1;
            default:   gen_next = gen_reg;
        endcase
    end

    assign target[0] = gen_next;
    assign target[1] = !gen_next;

    // Drop at once on a falling target, delay a rising one by the dead time
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            lvl_next[k] = lvl_reg[k];
            dly_next[k] = dly_reg[k];
            if (step.tick)
            begin
                if (!target[k])
                begin
                    lvl_next[k] = 1'b0;
                    dly_next[k] = '0;
                end
                else if (!lvl_reg[k])
                begin
                    if (dly_reg[k] >= dead_len)
                    begin
                        lvl_next[k] = 1'b1;
                    end
                    else
                    begin
                        dly_next[k] = dly_reg[k] + DEAD_WIDTH'(1);
                    end
                end
            end
        end
    end

    assign high_next = lvl_next[0];
    assign low_next  = lvl_next[1];

    // Hold phase state, advance on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= 1'b0;
            for (int k = 0; k < 2; k++)
            begin
                lvl_reg[k] <= 1'b0;
                dly_reg[k] <= '0;
            end
        end
        else if (fire)
        begin
            gen_reg <= gen_next;
            for (int k = 0; k < 2; k++)
            begin
                lvl_reg[k] <= lvl_next[k];
                dly_reg[k] <= dly_next[k];
            end
        end
    end

endmodule

// ===== design/tpwm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpwm_checker: port-level checks for the three-phase PWM block
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module tpwm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_stall,
    input  tpwm_pkg::out_beat_t                 out_data,
    input  logic                                out_valid,
    input  logic                                out_stall
);
    import tpwm_pkg::*;

    // A stalled result beat stays and holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Input backs up only behind a held result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // Complementary drives of a phase are never on together
    a_shoot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.high_a && out_data.low_a) &&
                      !(out_data.high_b && out_data.low_b) &&
                      !(out_data.high_c && out_data.low_c))
        else $error("both drives of a phase on");

    // At zero the counter is always in its upward half
    a_zero_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.count_now == '0) |-> !out_data.counting_down)
        else $error("counting down at zero");

endmodule

bind three_phase_center_pwm_deadband tpwm_checker u_tpwm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
);
